// ===== hdl/lqr_gain_kleinman_solver_assert.svh =====
// Assertion macros shared by the solver RTL.
`ifndef LQR_GAIN_KLEINMAN_SOLVER_ASSERT_SVH
`define LQR_GAIN_KLEINMAN_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
`define LQR_ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define LQR_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define LQR_ASSERT_CLK(label, clk, rst, prop)
`define LQR_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== hdl/lqr_pkg.sv =====
// Package with types, constants and helpers for the Kleinman LQR solver.
package lqr_pkg;
  localparam int DefFracBits = 16;
  localparam int QW = 64;
  localparam int PORTW = 31;
  localparam logic [9:0] DefMaxIter = 10'd300;
  localparam logic [63:0] SatMax = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_ZERO_DIV  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAX_ITER = 2'd0,
    CFG_TOL      = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_K0, S_PASS, S_A21, S_A22, S_RK0, S_E11, S_RK1, S_E22, S_D4, S_D,
    S_D1A, S_D1, S_D2A, S_D2B, S_D2C, S_CHK, S_P12, S_N0A, S_N0, S_P22, S_N1A,
    S_N1, S_DONE
  } state_t;

  typedef struct packed {
    logic   go;
    op_t    op;
  } alu_ctl_t;

  function automatic logic [63:0] mag64(input logic [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) sat_add = SatMax;
    else if (a[63] && b[63] && (!s[63] || s == 64'h8000_0000_0000_0000))
      sat_add = 64'd0 - SatMax;
    else sat_add = s;
  endfunction
endpackage

// ===== hdl/lqr_gain_kleinman_solver.sv =====
// Top level of the Kleinman LQR gain solver with its sequencer and register file.
//
//  channel  direction  signals
//  command  in         start, busy, plant_gain, weight_angle, weight_rate, weight_input
//  result   out        done, gain_angle, gain_rate, status, iterations_used
//  config   in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A command beat is taken when start is high and busy low. Every multiply and every
// divide holds its sequencer step until the shared bit-serial unit reports done;
// a pass holds fifteen multiplies, four divides and the bookkeeping states S_PASS
// and S_CHK. The result is on the ports for one cycle under done; the receiver
// cannot stall it. Reset is synchronous and restores the register defaults.
// Config beats are always taken.
module lqr_gain_kleinman_solver import lqr_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [30:0] plant_gain,
  input  logic [30:0] weight_angle,
  input  logic [30:0] weight_rate,
  input  logic [30:0] weight_input,
  output logic        done,
  output logic [31:0] gain_angle,
  output logic [31:0] gain_rate,
  output logic [1:0]  status,
  output logic [9:0]  iterations_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int SH = 32 - FRAC_BITS;

  logic [9:0]  max_iter;
  logic [15:0] tol_lsb;
  logic [63:0] b, q1, q2, r, k0, k1, a21, a22, e11, e22, d, d1, d2, t, n0;
  logic [9:0]  it;
  state_t      state, state_next;
  alu_ctl_t    ctl;
  logic [63:0] opa, opb, y;
  logic        alu_done, issued;
  logic [63:0] one2, one4;

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE) || done;
  assign one2 = 64'h2_0000_0000;
  assign one4 = 64'h4_0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= DefMaxIter;
      tol_lsb  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_ITER: max_iter <= cfg_data[9:0];
        CFG_TOL:      tol_lsb  <= cfg_data;
        default: ;
      endcase
    end
  end

  lqr_alu u_alu (.clk, .rst, .ctl, .a(opa), .b(opb), .done(alu_done), .y);

  // Operand selection for each sequencer step.
  always_comb begin
    ctl.op = OP_MUL;
    opa = b;
    opb = k0;
    case (state)
      S_K0:  begin ctl.op = OP_DIV; opa = one4; opb = b; end
      S_A21: begin opa = b; opb = k0; end
      S_A22: begin opa = b; opb = k1; end
      S_RK0: begin opa = r; opb = k0; end
      S_E11: begin opa = t; opb = k0; end
      S_RK1: begin opa = r; opb = k1; end
      S_E22: begin opa = t; opb = k1; end
      S_D4:  begin opa = one4; opb = a21; end
      S_D:   begin opa = t; opb = a22; end
      S_D1A: begin opa = one2; opb = a22; end
      S_D1:  begin opa = t; opb = e11; end
      S_D2A: begin opa = one2; opb = a21; end
      S_D2B: begin opa = t; opb = e22; end
      S_D2C: begin opa = one2; opb = e11; end
      S_P12: begin ctl.op = OP_DIV; opa = d1; opb = d; end
      S_N0A: begin opa = b; opb = t; end
      S_N0:  begin ctl.op = OP_DIV; opa = t; opb = r; end
      S_P22: begin ctl.op = OP_DIV; opa = d2; opb = d; end
      S_N1A: begin opa = b; opb = t; end
      S_N1:  begin ctl.op = OP_DIV; opa = t; opb = r; end
      default: ;
    endcase
    ctl.go = !issued && (state inside {S_K0, S_A21, S_A22, S_RK0, S_E11, S_RK1,
      S_E22, S_D4, S_D, S_D1A, S_D1, S_D2A, S_D2B, S_D2C, S_P12, S_N0A, S_N0,
      S_P22, S_N1A, S_N1});
  end

  logic [63:0] tol, dk0, dk1;
  logic        conv;
  always_comb begin
    tol = {48'd0, tol_lsb} << SH;
    dk0 = mag64(sat_add(n0, 64'd0 - k0));
    dk1 = mag64(sat_add(y, 64'd0 - k1));
    conv = (dk0 <= tol) && (dk1 <= tol);
  end

  function automatic logic [31:0] port_out(input logic [63:0] v);
    logic [63:0] m;
    m = mag64(v) >> SH;
    if (v[63]) port_out = (m > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    else port_out = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start && !busy) begin
        state_next = (plant_gain == 31'd0 || weight_input == 31'd0) ? S_IDLE : S_K0;
      end
      S_K0:    if (alu_done) state_next = S_PASS;
      S_PASS:  state_next = (it == max_iter) ? S_DONE : S_A21;
      S_A21:   if (alu_done) state_next = S_A22;
      S_A22:   if (alu_done) state_next = S_RK0;
      S_RK0:   if (alu_done) state_next = S_E11;
      S_E11:   if (alu_done) state_next = S_RK1;
      S_RK1:   if (alu_done) state_next = S_E22;
      S_E22:   if (alu_done) state_next = S_D4;
      S_D4:    if (alu_done) state_next = S_D;
      S_D:     if (alu_done) state_next = S_D1A;
      S_D1A:   if (alu_done) state_next = S_D1;
      S_D1:    if (alu_done) state_next = S_D2A;
      S_D2A:   if (alu_done) state_next = S_D2B;
      S_D2B:   if (alu_done) state_next = S_D2C;
      S_D2C:   if (alu_done) state_next = S_CHK;
      S_CHK:   state_next = (d == 64'd0) ? S_IDLE : S_P12;
      S_P12:   if (alu_done) state_next = S_N0A;
      S_N0A:   if (alu_done) state_next = S_N0;
      S_N0:    if (alu_done) state_next = S_P22;
      S_P22:   if (alu_done) state_next = S_N1A;
      S_N1A:   if (alu_done) state_next = S_N1;
      S_N1:    if (alu_done) state_next = conv ? S_IDLE : S_PASS;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done   <= 1'b0;
      issued <= 1'b0;
    end else begin
      done  <= 1'b0;
      if (alu_done) issued <= 1'b0;
      else if (ctl.go) issued <= 1'b1;
      case (state)
        S_IDLE: if (start && !busy) begin
          b  <= 64'(plant_gain) << SH;
          q1 <= 64'(weight_angle) << SH;
          q2 <= 64'(weight_rate) << SH;
          r  <= 64'(weight_input) << SH;
          it <= '0;
          if (plant_gain == 31'd0 || weight_input == 31'd0) begin
            done <= 1'b1;
            gain_angle <= '0;
            gain_rate <= '0;
            status <= ST_ZERO_DIV;
            iterations_used <= '0;
          end
        end
        S_K0:  if (alu_done) begin k0 <= y; k1 <= y; end
        S_A21: if (alu_done) a21 <= 64'd0 - y;
        S_A22: if (alu_done) a22 <= 64'd0 - y;
        S_RK0, S_RK1, S_D4, S_D1A, S_D2A, S_P12, S_N0A, S_P22, S_N1A:
          if (alu_done) t <= y;
        S_E11: if (alu_done) e11 <= sat_add(q1, y);
        S_E22: if (alu_done) e22 <= sat_add(q2, y);
        S_D:   if (alu_done) d <= 64'd0 - y;
        S_D1:  if (alu_done) d1 <= y;
        S_D2B: if (alu_done) d2 <= y;
        S_D2C: if (alu_done) d2 <= sat_add(d2, 64'd0 - y);
        S_CHK: begin
          it <= it + 10'd1;
          if (d == 64'd0) begin
            done <= 1'b1;
            gain_angle <= '0;
            gain_rate <= '0;
            status <= ST_ZERO_DIV;
            iterations_used <= it + 10'd1;
          end
        end
        S_N0:  if (alu_done) n0 <= y;
        S_N1:  if (alu_done) begin
          k0 <= n0;
          k1 <= y;
          if (conv) begin
            gain_angle <= port_out(n0);
            gain_rate <= port_out(y);
            status <= ST_CONVERGED;
            iterations_used <= it;
            done <= 1'b1;
          end
        end
        S_DONE: begin
          gain_angle <= port_out(k0);
          gain_rate <= port_out(k1);
          status <= ST_LIMIT;
          iterations_used <= max_iter;
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `include "lqr_gain_kleinman_solver_assert.svh"
  `LQR_ASSERT_NEXT(a_done_idle, clk, rst, done, state == S_IDLE)
  `LQR_ASSERT_NEXT(a_start_runs, clk, rst, start && !busy && plant_gain != 31'd0
    && weight_input != 31'd0, state == S_K0)
  `LQR_ASSERT_CLK(a_it_bound, clk, rst, it <= max_iter || state == S_IDLE)
endmodule

// ===== hdl/lqr_alu.sv =====
// Bit-serial signed Q32.32 multiplier and divider, one bit per cycle.
module lqr_alu import lqr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  alu_ctl_t    ctl,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] y
);
  // Product accumulates in 128 bits; shift-add one multiplier bit per cycle.
  logic [127:0] acc;
  logic [63:0]  ma, mb;
  logic [63:0]  rem, q;
  logic [95:0]  num;
  logic         sat, neg, busy;
  op_t          op;
  logic [6:0]   cnt;
  logic [64:0]  trial;
  logic [63:0]  rsh;
  logic [63:0]  res_mag;

  always_comb begin
    rsh   = {rem[62:0], num[95]};
    trial = {1'b0, rsh} - {1'b0, mb};
    if (op == OP_MUL) res_mag = (acc[127:96] != 32'd0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                     : acc[95:32];
    else res_mag = sat ? 64'hFFFF_FFFF_FFFF_FFFF : q;
    if (res_mag > SatMax) res_mag = SatMax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.go && !busy) begin
        busy <= 1'b1;
        op   <= ctl.op;
        ma   <= mag64(a);
        mb   <= mag64(b);
        num  <= {mag64(a), 32'd0};
        neg  <= a[63] ^ b[63];
        acc  <= '0;
        rem  <= '0;
        q    <= '0;
        sat  <= 1'b0;
        cnt  <= (ctl.op == OP_MUL) ? 7'd64 : 7'd96;
      end else if (busy) begin
        if (cnt == 7'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          y    <= neg ? (64'd0 - res_mag) : res_mag;
        end else begin
          cnt <= cnt - 7'd1;
          if (op == OP_MUL) begin
            acc <= (acc << 1) + (ma[63] ? {64'd0, mb} : 128'd0);
            ma  <= {ma[62:0], 1'b0};
          end else begin
            num <= {num[94:0], 1'b0};
            if (q[63]) sat <= 1'b1;
            if (rem[63] || !trial[64]) begin
              rem <= rem[63] ? (rsh - mb) : trial[63:0];
              q   <= {q[62:0], 1'b1};
            end else begin
              rem <= rsh;
              q   <= {q[62:0], 1'b0};
            end
          end
        end
      end
    end
  end

  `include "lqr_gain_kleinman_solver_assert.svh"
  `LQR_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `LQR_ASSERT_NEXT(a_no_start_busy, clk, rst, ctl.go && !busy, busy)
  `LQR_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)
endmodule
